// File: sv/kbrx_pkg.sv
// kbrx_pkg: shared types, register indexes and byte rotate helpers
// for the keyed byte rotate-XOR cipher. No dependencies.
package kbrx_pkg;

	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LO   = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_KEY_HI   = 8'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LEN  = 8'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_DEC_MODE = 8'd3;

	localparam logic [4:0] KEY_LEN_RST = 5'd1;
	localparam logic [7:0] SUM_RST     = 8'h01;

	// key schedule status, visible to the top level
	typedef struct packed {
		logic [3:0] pos;
		logic [7:0] sum;
	} ks_stat_t;

	// per-word key material handed to the byte transform
	typedef struct packed {
		logic [7:0] v;
		logic [7:0] sum;
	} ks_word_t;

	function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] r);
		logic [15:0] d;
		d = {x, x} << r;
		return d[15:8];
	endfunction

	function automatic logic [7:0] rotr8(input logic [7:0] x, input logic [2:0] r);
		logic [15:0] d;
		d = {x, x} >> r;
		return d[7:0];
	endfunction

endpackage

// File: sv/kbrx_cfg.sv
// kbrx_cfg: configuration register file (key bytes, key length, mode)
// and effective key length clamp. Depends on kbrx_pkg.
module kbrx_cfg #(
	parameter int KEY_BYTES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kbrx_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [kbrx_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [7:0]                      key [KEY_BYTES],
	output logic [4:0]                      eff_len,
	output logic                            decrypt
);
	import kbrx_pkg::*;

	logic [7:0] key_q [KEY_BYTES];
	logic [4:0] klen_q;
	logic       dec_q;
	logic       wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_BYTES; i++) key_q[i] <= '0;
			klen_q <= KEY_LEN_RST;
			dec_q  <= 1'b0;
		end else if (wr) begin
			for (int i = 0; i < KEY_BYTES; i++) begin
				if ((i < 8 && cfg_addr == CFG_KEY_LO) || (i >= 8 && cfg_addr == CFG_KEY_HI))
					key_q[i] <= cfg_data[8*(i%8) +: 8];
			end
			if (cfg_addr == CFG_KEY_LEN)  klen_q <= cfg_data[4:0];
			if (cfg_addr == CFG_DEC_MODE) dec_q  <= cfg_data[0];
		end
	end

	// zero acts as one, anything above the key storage saturates
	always_comb begin
		if (klen_q == 5'd0)                eff_len = 5'd1;
		else if (klen_q > 5'(KEY_BYTES))   eff_len = 5'(KEY_BYTES);
		else                               eff_len = klen_q;
	end

	assign key     = key_q;
	assign decrypt = dec_q;

endmodule

// File: sv/kbrx_keysched.sv
// kbrx_keysched: key position and running sum state; picks the key byte
// for the current word and the updated sum. Depends on kbrx_pkg.
module kbrx_keysched #(
	parameter int KEY_BYTES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               first,
	input  logic [7:0]         key [KEY_BYTES],
	input  logic [4:0]         eff_len,
	output kbrx_pkg::ks_word_t word,
	output kbrx_pkg::ks_stat_t stat
);
	import kbrx_pkg::*;

	localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic [3:0] pos_base;
	logic [3:0] pos_use;
	logic [4:0] pos_inc;
	logic [3:0] pos_nx;
	logic [7:0] sum_base;
	logic [7:0] v;

	always_comb begin
		pos_base = first ? 4'd0 : pos_q;
		sum_base = first ? {3'b000, eff_len} : sum_q;
		// stale position after a length change falls back to byte 0
		pos_use  = ({1'b0, pos_base} >= eff_len) ? 4'd0 : pos_base;
		v        = key[pos_use[KIDX_W-1:0]];
		pos_inc  = {1'b0, pos_use} + 5'd1;
		pos_nx   = (pos_inc >= eff_len) ? 4'd0 : pos_inc[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
			sum_q <= SUM_RST;
		end else if (step) begin
			pos_q <= pos_nx;
			sum_q <= sum_base + v;
		end
	end

	assign word.v   = v;
	assign word.sum = sum_base + v;
	assign stat.pos = pos_q;
	assign stat.sum = sum_q;

endmodule

// File: sv/kbrx_xform.sv
// kbrx_xform: one-byte encrypt/decrypt datapath (XOR, barrel rotate, XOR).
// Depends on kbrx_pkg.
module kbrx_xform (
	input  logic [7:0]         data,
	input  logic               decrypt,
	input  kbrx_pkg::ks_word_t word,
	output logic [7:0]         result
);
	import kbrx_pkg::*;

	logic [7:0] t;

	always_comb begin
		if (decrypt) begin
			t      = rotr8(data ^ word.sum, word.v[2:0]);
			result = t ^ word.v;
		end else begin
			t      = rotl8(data ^ word.v, word.v[2:0]);
			result = t ^ word.sum;
		end
	end

endmodule

// File: sv/keyed_byte_rotate_xor_cipher_unit.sv
// keyed_byte_rotate_xor_cipher_unit: top level of the keyed byte cipher.
// Uses kbrx_pkg, kbrx_cfg, kbrx_keysched and kbrx_xform.
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+----------------------------------------
// s_*     | in  | s_tvalid/s_tready  | tdata = data_byte, tuser = first_of_message
// m_*     | out | m_tvalid/m_tready  | tdata = result_byte
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_addr = register index, cfg_data
//
// Two register stages: an input register (s1) and a result register (s2).
// One word per cycle sustained while m_tready holds high: key pick, sum add and
// barrel rotate all sit between s1 and s2. m_tvalid rises once an accepted
// word has moved from s1 into s2, and the result leaves from the s2 register.
// Key position and running sum advance when a word moves from s1 to s2.
// A stalled m_tready holds s2; s1 still takes one more word, then s_tready drops.
// arst_n clears valids, key registers, key length (1), mode and cipher state.
module keyed_byte_rotate_xor_cipher_unit #(
	parameter int KEY_BYTES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_byte
	input  logic                            s_tuser,   // [0] first_of_message
	// master stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] result_byte
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kbrx_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [kbrx_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kbrx_pkg::*;

	logic [7:0] key [KEY_BYTES];
	logic [4:0] eff_len;
	logic       decrypt;

	// input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	// result stage
	logic       valid_s2;
	logic [7:0] result_s2;

	logic       adv_s1;    // s1 word moves into s2 this cycle
	logic       free_s2;
	logic       s_acc;
	ks_word_t   kword;
	ks_stat_t   kstat;
	logic [7:0] result;

	kbrx_cfg #(.KEY_BYTES(KEY_BYTES)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.key       (key),
		.eff_len   (eff_len),
		.decrypt   (decrypt)
	);

	kbrx_keysched #(.KEY_BYTES(KEY_BYTES)) u_ks (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.first   (first_s1),
		.key     (key),
		.eff_len (eff_len),
		.word    (kword),
		.stat    (kstat)
	);

	kbrx_xform u_xf (
		.data    (data_s1),
		.decrypt (decrypt),
		.word    (kword),
		.result  (result)
	);

	// s2 frees up when empty or drained this cycle; s1 likewise from s2
	assign free_s2  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && free_s2;
	assign s_tready = !valid_s1 || free_s2;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (free_s2)  valid_s2 <= valid_s1;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (s_acc) begin
			data_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
		if (adv_s1) result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	// key position never points past the key storage
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, kstat.pos} < 5'(KEY_BYTES))
		else $error("key position beyond key storage");

	// a word only moves into s2 when s2 can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |-> (!valid_s2 || m_tready))
		else $error("s2 overwritten while holding a word");

	// a held s1 word stays put until it advances
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(data_s1) && $stable(first_s1)))
		else $error("s1 word lost while stalled");

	// start of message: sum restarts at key length plus first key byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && first_s1) |=> (kstat.sum == $past({3'b000, eff_len} + key[0])))
		else $error("running sum not restarted on first word");

	// key state only moves when a word advances
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(kstat.pos) && $stable(kstat.sum)))
		else $error("key state changed without a word");

endmodule
